// ----- sv/uct_pkg.sv -----
// ----------------------------------------------------------------------------
// URL component tokenizer package
// Shared types, state encodings and part codes of the URL tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package uct_pkg;

  localparam int unsigned MAX_PAIRS_DEF = 16;
  localparam int unsigned MAX_RESULTS   = 6;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int unsigned PAIR_W        = 5;
  localparam logic [PAIR_W-1:0] PAIR_SAT = '1;

  // Part codes carried in each token.
  localparam logic [2:0] PART_HOST    = 3'd0;
  localparam logic [2:0] PART_PATH    = 3'd1;
  localparam logic [2:0] PART_KEY     = 3'd2;
  localparam logic [2:0] PART_VALUE   = 3'd3;
  localparam logic [2:0] PART_FRAG    = 3'd4;
  localparam logic [2:0] PART_DISCARD = 3'd5;

  typedef enum logic [6:0] {
    PH_HOST  = 7'b0000001,
    PH_PATH  = 7'b0000010,
    PH_KEY   = 7'b0000100,
    PH_VALUE = 7'b0001000,
    PH_FRAG  = 7'b0010000,
    PH_HOST2 = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } uct_phase_t;

  typedef enum logic [2:0] {
    SCH_NONE        = 3'b001,
    SCH_COLON       = 3'b010,
    SCH_COLON_SLASH = 3'b100
  } uct_scheme_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX  = 3'b100
  } uct_esc_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uct_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] part;
    logic       part_end;
    logic       url_done;
  } uct_tok_t;

  typedef uct_tok_t [MAX_RESULTS-1:0] uct_res_list_t;

  typedef struct packed {
    uct_phase_t        phase;
    uct_scheme_t       scheme;
    uct_esc_t          esc;
    logic [7:0]        held_char;
    logic [PAIR_W-1:0] pair_count;
    logic              path_seen;
  } uct_state_t;

  localparam uct_state_t STATE_RESET = '{
    phase:      PH_HOST,
    scheme:     SCH_NONE,
    esc:        ESC_NONE,
    held_char:  8'h00,
    pair_count: '0,
    path_seen:  1'b0
  };

endpackage

`default_nettype wire

// ----- sv/uct_step.sv -----
// ----------------------------------------------------------------------------
// URL tokenizer step logic
// Decides the tokens and the next parser state for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module uct_step #(
  parameter int unsigned MAX_PAIRS = uct_pkg::MAX_PAIRS_DEF
) (
  input  wire uct_pkg::uct_in_t       item,
  input  wire uct_pkg::uct_state_t    st,
  output uct_pkg::uct_state_t         st_next,
  output uct_pkg::uct_res_list_t      results,
  output logic [uct_pkg::CNT_W-1:0]   count
);

  localparam int unsigned CW = uct_pkg::CNT_W;
  localparam int unsigned PW = uct_pkg::PAIR_W;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef struct packed {
    uct_pkg::uct_state_t    st;
    logic [CW-1:0]          n;
    uct_pkg::uct_res_list_t res;
  } ctx_t;

  ctx_t x;

  // Returns {valid, value} of a hex digit.
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [2:0] part_of(uct_pkg::uct_phase_t ph);
    logic [2:0] p;
    case (ph)
      uct_pkg::PH_KEY: p = uct_pkg::PART_KEY;
      default:         p = uct_pkg::PART_VALUE;
    endcase
    return p;
  endfunction

  function automatic ctx_t put(ctx_t xi, logic [7:0] b, logic has, logic [2:0] part,
                               logic fin);
    ctx_t            xo;
    uct_pkg::uct_tok_t t;
    xo         = xi;
    t.out_byte = has ? b : 8'h00;
    t.has_byte = has;
    t.part     = part;
    t.part_end = fin;
    t.url_done = 1'b0;
    if (xo.n < CW'(uct_pkg::MAX_RESULTS)) begin
      xo.res[xo.n] = t;
      xo.n         = xo.n + 1'b1;
    end
    return xo;
  endfunction

  function automatic ctx_t close_host(ctx_t xi);
    ctx_t xo;
    xo = put(xi, 8'h00, 1'b0, uct_pkg::PART_HOST, 1'b1);
    if (!xo.st.path_seen) begin
      xo = put(xo, CH_SLASH, 1'b1, uct_pkg::PART_PATH, 1'b1);
    end
    xo.st.path_seen = 1'b1;
    return xo;
  endfunction

  function automatic ctx_t host_plain(ctx_t xi, logic [7:0] c);
    ctx_t xo;
    xo = xi;
    case (c)
      CH_SLASH: begin
        xo              = put(xo, 8'h00, 1'b0, uct_pkg::PART_HOST, 1'b1);
        xo              = put(xo, CH_SLASH, 1'b1, uct_pkg::PART_PATH, 1'b0);
        xo.st.path_seen = 1'b1;
        xo.st.phase     = uct_pkg::PH_PATH;
      end
      CH_QUEST: begin
        xo          = close_host(xo);
        xo.st.phase = uct_pkg::PH_KEY;
      end
      CH_HASH: begin
        xo          = close_host(xo);
        xo.st.phase = uct_pkg::PH_FRAG;
      end
      default: begin
        xo = put(xo, c, 1'b1, uct_pkg::PART_HOST, 1'b0);
      end
    endcase
    return xo;
  endfunction

  function automatic ctx_t path_byte(ctx_t xi, logic [7:0] c);
    ctx_t xo;
    xo = xi;
    if (c == CH_QUEST) begin
      xo          = put(xo, 8'h00, 1'b0, uct_pkg::PART_PATH, 1'b1);
      xo.st.phase = uct_pkg::PH_KEY;
    end else if (c == CH_HASH) begin
      xo          = put(xo, 8'h00, 1'b0, uct_pkg::PART_PATH, 1'b1);
      xo.st.phase = uct_pkg::PH_FRAG;
    end else begin
      xo = put(xo, c, 1'b1, uct_pkg::PART_PATH, 1'b0);
    end
    return xo;
  endfunction

  function automatic ctx_t host_byte(ctx_t xi, logic [7:0] c);
    ctx_t xo;
    xo = xi;
    if (xo.st.phase == uct_pkg::PH_HOST2) begin
      xo = host_plain(xo, c);
    end else begin
      case (xo.st.scheme)
        uct_pkg::SCH_COLON: begin
          xo.st.scheme = uct_pkg::SCH_NONE;
          if (c == CH_SLASH) begin
            xo.st.scheme = uct_pkg::SCH_COLON_SLASH;
          end else begin
            // The held colon was ordinary host text.
            xo = put(xo, CH_COLON, 1'b1, uct_pkg::PART_HOST, 1'b0);
            if (c == CH_COLON) begin
              xo.st.scheme = uct_pkg::SCH_COLON;
            end else begin
              xo = host_plain(xo, c);
            end
          end
        end
        uct_pkg::SCH_COLON_SLASH: begin
          xo.st.scheme = uct_pkg::SCH_NONE;
          if (c == CH_SLASH) begin
            xo          = put(xo, 8'h00, 1'b0, uct_pkg::PART_DISCARD, 1'b1);
            xo.st.phase = uct_pkg::PH_HOST2;
          end else begin
            // The held slash ends the host; this byte is then a path byte.
            xo = put(xo, CH_COLON, 1'b1, uct_pkg::PART_HOST, 1'b0);
            xo = host_plain(xo, CH_SLASH);
            xo = path_byte(xo, c);
          end
        end
        default: begin
          if (c == CH_COLON) begin
            xo.st.scheme = uct_pkg::SCH_COLON;
          end else begin
            xo = host_plain(xo, c);
          end
        end
      endcase
    end
    return xo;
  endfunction

  function automatic ctx_t close_pair(ctx_t xi);
    ctx_t xo;
    xo = xi;
    if (xo.st.esc == uct_pkg::ESC_HEX) begin
      xo = put(xo, xo.st.held_char, 1'b1, part_of(xo.st.phase), 1'b0);
    end
    xo.st.esc = uct_pkg::ESC_NONE;
    if (xo.st.phase == uct_pkg::PH_KEY) begin
      xo = put(xo, 8'h00, 1'b0, uct_pkg::PART_KEY, 1'b1);
    end
    xo = put(xo, 8'h00, 1'b0, uct_pkg::PART_VALUE, 1'b1);
    if (xo.st.pair_count != uct_pkg::PAIR_SAT) begin
      xo.st.pair_count = xo.st.pair_count + 1'b1;
    end
    return xo;
  endfunction

  function automatic ctx_t query_plain(ctx_t xi, logic [7:0] c);
    ctx_t xo;
    xo = xi;
    case (c)
      CH_PCT: begin
        xo.st.esc = uct_pkg::ESC_PCT;
      end
      CH_AMP: begin
        xo          = close_pair(xo);
        xo.st.phase = (xo.st.pair_count >= PW'(MAX_PAIRS)) ? uct_pkg::PH_SKIP
                                                             : uct_pkg::PH_KEY;
      end
      CH_HASH: begin
        xo          = close_pair(xo);
        xo.st.phase = uct_pkg::PH_FRAG;
      end
      CH_EQ: begin
        if (xo.st.phase == uct_pkg::PH_KEY) begin
          xo          = put(xo, 8'h00, 1'b0, uct_pkg::PART_KEY, 1'b1);
          xo.st.phase = uct_pkg::PH_VALUE;
        end else begin
          xo = put(xo, c, 1'b1, part_of(xo.st.phase), 1'b0);
        end
      end
      default: begin
        xo = put(xo, c, 1'b1, part_of(xo.st.phase), 1'b0);
      end
    endcase
    return xo;
  endfunction

  function automatic ctx_t query_byte(ctx_t xi, logic [7:0] c);
    ctx_t       xo;
    logic [4:0] hc;
    logic [4:0] hh;
    logic       plain;
    xo    = xi;
    hc    = hex_nib(c);
    hh    = hex_nib(xo.st.held_char);
    plain = 1'b1;
    case (xo.st.esc)
      uct_pkg::ESC_PCT: begin
        xo.st.esc = uct_pkg::ESC_NONE;
        if (hc[4]) begin
          xo.st.held_char = c;
          xo.st.esc       = uct_pkg::ESC_HEX;
          plain           = 1'b0;
        end
      end
      uct_pkg::ESC_HEX: begin
        xo.st.esc = uct_pkg::ESC_NONE;
        if (hc[4]) begin
          xo    = put(xo, {hh[3:0], hc[3:0]}, 1'b1, part_of(xo.st.phase), 1'b0);
          plain = 1'b0;
        end else begin
          // A broken escape keeps its first digit as a plain character.
          xo = put(xo, xo.st.held_char, 1'b1, part_of(xo.st.phase), 1'b0);
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      xo = query_plain(xo, c);
    end
    return xo;
  endfunction

  function automatic ctx_t finish(ctx_t xi);
    ctx_t xo;
    xo = xi;
    if (xo.st.phase == uct_pkg::PH_HOST) begin
      if (xo.st.scheme == uct_pkg::SCH_COLON) begin
        xo = put(xo, CH_COLON, 1'b1, uct_pkg::PART_HOST, 1'b0);
      end else if (xo.st.scheme == uct_pkg::SCH_COLON_SLASH) begin
        xo = put(xo, CH_COLON, 1'b1, uct_pkg::PART_HOST, 1'b0);
        xo = host_plain(xo, CH_SLASH);
      end
      xo.st.scheme = uct_pkg::SCH_NONE;
    end
    case (xo.st.phase)
      uct_pkg::PH_HOST,
      uct_pkg::PH_HOST2: xo = close_host(xo);
      uct_pkg::PH_PATH:  xo = put(xo, 8'h00, 1'b0, uct_pkg::PART_PATH, 1'b1);
      uct_pkg::PH_KEY,
      uct_pkg::PH_VALUE: xo = close_pair(xo);
      uct_pkg::PH_FRAG:  xo = put(xo, 8'h00, 1'b0, uct_pkg::PART_FRAG, 1'b1);
      default:           xo = xo;
    endcase
    // A skipped query leaves nothing open, so a bare token carries the end.
    if (xo.n == '0) begin
      xo = put(xo, 8'h00, 1'b0, uct_pkg::PART_KEY, 1'b0);
    end
    xo.res[xo.n - 1'b1].url_done = 1'b1;
    xo.st = uct_pkg::STATE_RESET;
    return xo;
  endfunction

  always_comb begin
    x.st  = st;
    x.n   = '0;
    x.res = '0;
    case (st.phase)
      uct_pkg::PH_HOST,
      uct_pkg::PH_HOST2: x = host_byte(x, item.in_byte);
      uct_pkg::PH_PATH:  x = path_byte(x, item.in_byte);
      uct_pkg::PH_KEY,
      uct_pkg::PH_VALUE: x = query_byte(x, item.in_byte);
      uct_pkg::PH_FRAG:  x = put(x, item.in_byte, 1'b1, uct_pkg::PART_FRAG, 1'b0);
      uct_pkg::PH_SKIP: begin
        if (item.in_byte == CH_HASH) begin
          x.st.phase = uct_pkg::PH_FRAG;
        end
      end
      default: x.st.phase = uct_pkg::PH_HOST;
    endcase
    if (item.in_last) begin
      x = finish(x);
    end
  end

  assign st_next = x.st;
  assign results = x.res;
  assign count   = x.n;

endmodule

`default_nettype wire

// ----- sv/url_component_tokenizer.sv -----
// ----------------------------------------------------------------------------
// URL component tokenizer
// Splits a URL byte stream into tagged host, path, query and fragment tokens.
// ----------------------------------------------------------------------------
// The block takes one URL character per beat and returns tokens, each tagged
// with its part and optionally closing it. A byte is registered, decoded
// combinationally against the parser state, and its tokens (none to six) are
// loaded into a result register that hands out one token per beat, so a
// byte's first token is offered after the input and result registers. A byte
// that yields at most one token frees the result register as that token
// leaves, so a stream sustains one byte per cycle while the sink is ready; a
// byte that yields k tokens holds the result register until all k have left
// it, one per beat. While earlier tokens wait, one more byte can enter the
// input register; the input then stalls until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module url_component_tokenizer #(
  parameter int unsigned MAX_PAIRS = uct_pkg::MAX_PAIRS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    byte_valid,
  output logic                   byte_ready,
  input  wire uct_pkg::uct_in_t  byte_data,
  output logic                   tok_valid,
  input  wire                    tok_ready,
  output uct_pkg::uct_tok_t      tok_data
);

  localparam int unsigned CW = uct_pkg::CNT_W;

  uct_pkg::uct_in_t       in_q;
  logic                   in_full;
  uct_pkg::uct_state_t    st;
  uct_pkg::uct_state_t    st_next;
  uct_pkg::uct_res_list_t res_q;
  uct_pkg::uct_res_list_t step_res;
  logic [CW-1:0]          res_n;
  logic [CW-1:0]          res_i;
  logic [CW-1:0]          step_n;
  logic                   drain;
  logic                   load;
  logic                   tok_fire;

  uct_step #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_step (
    .item    (in_q),
    .st      (st),
    .st_next (st_next),
    .results (step_res),
    .count   (step_n)
  );

  assign tok_valid = res_i < res_n;
  assign tok_data  = res_q[res_i];
  assign tok_fire  = tok_valid && tok_ready;

  // The result register is free when it is empty or its final token leaves this beat.
  assign drain      = (res_i == res_n) || (tok_fire && (res_i == res_n - 1'b1));
  assign load       = in_full && drain;
  assign byte_ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= uct_pkg::STATE_RESET;
      res_n <= '0;
      res_i <= '0;
    end else if (load) begin
      st    <= st_next;
      res_n <= step_n;
      res_i <= '0;
    end else if (tok_fire) begin
      res_i <= res_i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= step_res;
    end
  end

  a_index_in_range : assert property (@(posedge clk) disable iff (rst)
    res_i <= res_n)
    else $error("token index ran past the token count");

  a_load_shows : assert property (@(posedge clk) disable iff (rst)
    (load && step_n != '0) |=> tok_valid)
    else $error("loaded tokens were not offered");

  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_data.url_done) |-> (res_i == res_n - 1'b1))
    else $error("end of URL token is not the last token of its byte");

  a_no_load_while_busy : assert property (@(posedge clk) disable iff (rst)
    (tok_valid && !tok_ready) |-> !load)
    else $error("result register reloaded while a token is stalled");

endmodule

`default_nettype wire
